/* rtl/pelco_d_response_parser_defines.svh */
// Assertion macros for the Pelco-D response parser.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PELCO_D_RESPONSE_PARSER_DEFINES_SVH
`define PELCO_D_RESPONSE_PARSER_DEFINES_SVH

// same-cycle implication
`define PDRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PDRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pdrp_pkg.sv */
// Shared types and constants for the Pelco-D response parser.
// No dependencies.
package pdrp_pkg;

  localparam int FOV_W    = 15;
  localparam int POS_W    = 3;
  localparam int ZSHIFT   = 14;
  localparam int PROD_W   = 2 * FOV_W;

  localparam logic [7:0]       SYNC_BYTE  = 8'hFF;
  localparam logic [7:0]       CODE_ZOOM  = 8'hA7;
  localparam logic [7:0]       CODE_FOCUS = 8'h63;
  localparam logic [FOV_W-1:0] ZOOM_FULL  = 15'h4000;
  localparam logic [ZSHIFT-1:0] ROUND_ADD = 14'h3FFF;

  localparam logic [POS_W-1:0] POS_HUNT  = 3'd0;
  localparam logic [POS_W-1:0] POS_ADDR  = 3'd1;
  localparam logic [POS_W-1:0] POS_CODE  = 3'd3;
  localparam logic [POS_W-1:0] POS_HIGH  = 3'd4;
  localparam logic [POS_W-1:0] POS_LOW   = 3'd5;
  localparam logic [POS_W-1:0] POS_CSUM  = 3'd6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_CSUM = 2'd2;

  localparam logic [1:0] KIND_ZOOM  = 2'd0;
  localparam logic [1:0] KIND_FOCUS = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd2;

  localparam logic REG_WIDE = 1'b0;
  localparam logic REG_TELE = 1'b1;

  localparam logic [FOV_W-1:0] WIDE_RESET = 15'd6370;
  localparam logic [FOV_W-1:0] TELE_RESET = 15'd230;

  typedef struct packed {
    logic              is_frame;
    logic              sum_ok;
    logic [1:0]        kind;
    logic [7:0]        addr;
    logic [15:0]       value;
    logic              wide_ge;
    logic [FOV_W-1:0]  wide;
    logic [PROD_W-1:0] prod;
  } evt_t;

endpackage

/* rtl/pdrp_parse.sv */
// Frame tracking stage: sync hunt, byte collection, checksum, FOV product.
// Depends on pdrp_pkg.
module pdrp_parse (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      byte_v,
  input  logic [7:0]                byte_d,
  input  logic [pdrp_pkg::FOV_W-1:0] wide_fov,
  input  logic [pdrp_pkg::FOV_W-1:0] tele_fov,
  input  logic                      down_rdy,
  output logic                      rdy,
  output logic                      evt_v,
  output pdrp_pkg::evt_t            evt
);
  import pdrp_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [7:0]       code_r, code_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic [7:0]       lo_r, lo_nxt;
  logic             evt_v_r, evt_v_nxt;
  evt_t             evt_r, evt_nxt;
  logic             fire;
  logic             emit;
  logic [15:0]      value;
  logic [FOV_W-1:0] zclip;
  logic [FOV_W-1:0] diff;
  logic             ge;

  assign rdy   = !evt_v_r || down_rdy;
  assign fire  = byte_v && rdy;
  assign value = {hi_r, lo_r};
  assign ge    = wide_fov >= tele_fov;
  assign diff  = ge ? (wide_fov - tele_fov) : (tele_fov - wide_fov);
  assign zclip = (value > 16'(ZOOM_FULL)) ? ZOOM_FULL : value[FOV_W-1:0];

  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    addr_nxt = addr_r;
    code_nxt = code_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    emit     = 1'b0;

    evt_nxt.is_frame = 1'b0;
    evt_nxt.sum_ok   = byte_d == sum_r;
    if (code_r == CODE_ZOOM) begin
      evt_nxt.kind = KIND_ZOOM;
    end else if (code_r == CODE_FOCUS) begin
      evt_nxt.kind = KIND_FOCUS;
    end else begin
      evt_nxt.kind = KIND_OTHER;
    end
    evt_nxt.addr    = addr_r;
    evt_nxt.value   = value;
    evt_nxt.wide_ge = ge;
    evt_nxt.wide    = wide_fov;
    evt_nxt.prod    = PROD_W'(diff) * PROD_W'(zclip);

    case (pos_r)
      POS_HUNT: begin
        if (byte_d != SYNC_BYTE) begin
          emit = 1'b1;
        end else begin
          pos_nxt = POS_ADDR;
          sum_nxt = 8'd0;
        end
      end
      POS_CSUM: begin
        pos_nxt          = POS_HUNT;
        emit             = 1'b1;
        evt_nxt.is_frame = 1'b1;
      end
      default: begin
        sum_nxt = sum_r + byte_d;
        pos_nxt = pos_r + 3'd1;
        case (pos_r)
          POS_ADDR: addr_nxt = byte_d;
          POS_CODE: code_nxt = byte_d;
          POS_HIGH: hi_nxt   = byte_d;
          POS_LOW:  lo_nxt   = byte_d;
          default: ;
        endcase
      end
    endcase

    evt_v_nxt = evt_v_r;
    if (fire) begin
      evt_v_nxt = emit;
    end else if (down_rdy) begin
      evt_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_HUNT;
      sum_r   <= 8'd0;
      evt_v_r <= 1'b0;
    end else begin
      evt_v_r <= evt_v_nxt;
      if (fire) begin
        pos_r <= pos_nxt;
        sum_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      addr_r <= addr_nxt;
      code_r <= code_nxt;
      hi_r   <= hi_nxt;
      lo_r   <= lo_nxt;
      evt_r  <= evt_nxt;
    end
  end

  assign evt_v = evt_v_r;
  assign evt   = evt_r;

endmodule

/* rtl/pdrp_update.sv */
// Result stage: finishes the FOV, updates stored camera data, result register.
// Depends on pdrp_pkg.
module pdrp_update (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       evt_v,
  input  pdrp_pkg::evt_t             evt,
  output logic                       rdy,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [1:0]                 out_response_kind,
  output logic [7:0]                 out_frame_address,
  output logic [15:0]                out_zoom_position,
  output logic [15:0]                out_focus_position,
  output logic [pdrp_pkg::FOV_W-1:0] out_field_of_view,
  output logic                       out_changed
);
  import pdrp_pkg::*;

  logic [15:0]       zoom_r, zoom_nxt;
  logic [15:0]       focus_r, focus_nxt;
  logic [FOV_W-1:0]  fov_r, fov_nxt;
  logic              out_v_r;
  logic [1:0]        status_r, status_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [7:0]        addr_r, addr_nxt;
  logic              changed_r, changed_nxt;
  logic              fire;
  logic [PROD_W:0]   rnd;
  logic [FOV_W-1:0]  step;
  logic [FOV_W-1:0]  fov_new;

  assign rdy  = !out_v_r || !out_stall;
  assign fire = evt_v && rdy;

  assign rnd     = {1'b0, evt.prod} + {{(PROD_W + 1 - ZSHIFT){1'b0}}, ROUND_ADD};
  assign step    = evt.wide_ge ? rnd[ZSHIFT+FOV_W-1:ZSHIFT]
                               : evt.prod[ZSHIFT+FOV_W-1:ZSHIFT];
  assign fov_new = evt.wide_ge ? (evt.wide - step) : (evt.wide + step);

  always_comb begin
    zoom_nxt    = zoom_r;
    focus_nxt   = focus_r;
    fov_nxt     = fov_r;
    changed_nxt = 1'b0;
    kind_nxt    = evt.kind;
    addr_nxt    = evt.addr;
    if (!evt.is_frame) begin
      status_nxt = ST_DROP;
      kind_nxt   = KIND_ZOOM;
      addr_nxt   = 8'd0;
    end else if (!evt.sum_ok) begin
      status_nxt = ST_CSUM;
    end else begin
      status_nxt = ST_OK;
      case (evt.kind)
        KIND_ZOOM: begin
          zoom_nxt    = evt.value;
          fov_nxt     = fov_new;
          changed_nxt = (evt.value != zoom_r) || (fov_new != fov_r);
        end
        KIND_FOCUS: begin
          focus_nxt   = evt.value;
          changed_nxt = evt.value != focus_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      zoom_r  <= 16'd0;
      focus_r <= 16'd0;
      fov_r   <= '0;
    end else begin
      if (fire) begin
        out_v_r <= 1'b1;
        zoom_r  <= zoom_nxt;
        focus_r <= focus_nxt;
        fov_r   <= fov_nxt;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r  <= status_nxt;
      kind_r    <= kind_nxt;
      addr_r    <= addr_nxt;
      changed_r <= changed_nxt;
    end
  end

  assign out_valid          = out_v_r;
  assign out_status         = status_r;
  assign out_response_kind  = kind_r;
  assign out_frame_address  = addr_r;
  assign out_zoom_position  = zoom_r;
  assign out_focus_position = focus_r;
  assign out_field_of_view  = fov_r;
  assign out_changed        = changed_r;

endmodule

/* rtl/pelco_d_response_parser.sv */
// The result is registered in turn by the input register, the parse stage and
// the result register.
// Throughput: one byte per cycle while out_stall is low; the parse and result
// stages each hold one item and advance whenever the next slot frees.
// Only sync-drop and frame-complete bytes produce a result transfer.
// Reset (rst_n low, synchronous): hunting for sync, stored data zero,
// FOV registers at 6370 and 230.
`include "pelco_d_response_parser_defines.svh"

module pelco_d_response_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [1:0]                 out_response_kind,
  output logic [7:0]                 out_frame_address,
  output logic [15:0]                out_zoom_position,
  output logic [15:0]                out_focus_position,
  output logic [pdrp_pkg::FOV_W-1:0] out_field_of_view,
  output logic                       out_changed,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [pdrp_pkg::FOV_W-1:0] cfg_data
);
  import pdrp_pkg::*;

  logic             in_v_r;
  logic [7:0]       in_byte_r;
  logic [FOV_W-1:0] wide_r;
  logic [FOV_W-1:0] tele_r;
  logic             parse_rdy;
  logic             upd_rdy;
  logic             evt_v;
  evt_t             evt;

  assign cfg_ready = 1'b1;
  assign in_stall  = in_v_r && !parse_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= WIDE_RESET;
      tele_r <= TELE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDE: wide_r <= cfg_data;
        REG_TELE: tele_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  pdrp_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_v   (in_v_r),
    .byte_d   (in_byte_r),
    .wide_fov (wide_r),
    .tele_fov (tele_r),
    .down_rdy (upd_rdy),
    .rdy      (parse_rdy),
    .evt_v    (evt_v),
    .evt      (evt)
  );

  pdrp_update u_update (
    .clk                (clk),
    .rst_n              (rst_n),
    .evt_v              (evt_v),
    .evt                (evt),
    .rdy                (upd_rdy),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_response_kind  (out_response_kind),
    .out_frame_address  (out_frame_address),
    .out_zoom_position  (out_zoom_position),
    .out_focus_position (out_focus_position),
    .out_field_of_view  (out_field_of_view),
    .out_changed        (out_changed)
  );

  `PDRP_ASSERT_NOW(a_drop_clean, out_valid && (out_status == ST_DROP), !out_changed && (out_frame_address == 8'd0) && (out_response_kind == KIND_ZOOM), "dropped byte result not clean")
  `PDRP_ASSERT_NOW(a_csum_nochg, out_valid && (out_status == ST_CSUM), !out_changed, "checksum mismatch reported a change")
  `PDRP_ASSERT_NOW(a_stall_src, in_stall, out_valid && out_stall, "input stalled without result backpressure")
  `PDRP_ASSERT_NEXT(a_store_hold, out_valid && out_stall, $stable(out_zoom_position) && $stable(out_field_of_view), "stored data moved under a stalled result")

endmodule
